[rtl/core/rwwf_pkg.sv]
// Shared constants and types of the range weighted window filter.
package rwwf_pkg;

  localparam int unsigned WIN        = 5;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned RING       = WIN * MAX_WIDTH;
  localparam int unsigned PTR_W      = $clog2(RING);
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT) + 1;
  localparam int unsigned WIN_W      = $clog2(WIN + 1);
  localparam int unsigned SW_W       = 16 + $clog2(WIN * WIN + 1);
  localparam int unsigned SWV_W      = SW_W + 8;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic centre;
    logic elem;
    logic last;
  } lane_ctrl_t;

endpackage

[rtl/core/rwwf_in_if.sv]
// Input item channel.
interface rwwf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic        start_of_frame;
  logic [7:0]  table_index;
  logic [15:0] table_weight;

  modport source (output valid, kind, pixel_red, pixel_green, pixel_blue, start_of_frame,
                  table_index, table_weight, input ready);
  modport sink (input valid, kind, pixel_red, pixel_green, pixel_blue, start_of_frame,
                table_index, table_weight, output ready);
endinterface

[rtl/core/rwwf_out_if.sv]
// Result item channel.
interface rwwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last_of_frame;

  modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
  modport sink (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

[rtl/core/rwwf_lane.sv]
// One colour channel lane: range weight lookup, accumulation and division.
module rwwf_lane import rwwf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tbl_we_i,
  input  logic [7:0] tbl_idx_i,
  input  logic [15:0] tbl_data_i,
  input  lane_ctrl_t ctrl_i,
  input  logic [7:0] pix_i,
  output logic [7:0] res_o,
  output logic       done_o
);

  logic [15:0] tbl [256];
  logic [7:0]  ctr_q;
  logic [7:0]  diff;
  logic [15:0] wt_q;
  logic [7:0]  v2_q;
  logic        elem2_q, last2_q, elem3_q, last3_q, last4_q;
  logic [23:0] prod_q;
  logic [15:0] wt3_q;
  logic [SW_W-1:0]  sw_q;
  logic [SWV_W-1:0] swv_q;
  logic [SWV_W-1:0] rem_q, dsh_q;
  logic [7:0]  quo_q;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;

  assign diff = (ctr_q >= pix_i) ? (ctr_q - pix_i) : (pix_i - ctr_q);

  always_ff @(posedge clk_i) begin
    if (tbl_we_i) begin
      tbl[tbl_idx_i] <= tbl_data_i;
    end
    wt_q <= tbl[diff];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.centre) begin
      ctr_q <= pix_i;
    end
    v2_q   <= pix_i;
    prod_q <= wt_q * v2_q;
    wt3_q  <= wt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem2_q <= 1'b0;
      last2_q <= 1'b0;
      elem3_q <= 1'b0;
      last3_q <= 1'b0;
      last4_q <= 1'b0;
      sw_q    <= '0;
      swv_q   <= '0;
      rem_q   <= '0;
      dsh_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      elem2_q <= ctrl_i.elem;
      last2_q <= ctrl_i.last;
      elem3_q <= elem2_q;
      last3_q <= last2_q;
      last4_q <= last3_q;
      done_q  <= 1'b0;
      if (ctrl_i.centre) begin
        sw_q  <= '0;
        swv_q <= '0;
      end else if (elem3_q) begin
        sw_q  <= sw_q + SW_W'(wt3_q);
        swv_q <= swv_q + SWV_W'(prod_q);
      end
      if (last4_q) begin
        rem_q  <= swv_q;
        dsh_q  <= SWV_W'(sw_q) << 7;
        quo_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[6:0], 1'b1};
        end else begin
          quo_q <= {quo_q[6:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o  = (sw_q == '0) ? 8'd0 : quo_q;
  assign done_o = done_q;

endmodule

[rtl/core/range_weighted_window_filter_unit.sv]
// Top level: raster control, line store, window sequencer, lanes and output stage.
// Items that give no result leave the unit idle; the next item is taken in the cycle after.
// An item that gives a result holds the input until its result enters the output register,
// which may wait on the consumer: a raster position divide, 26 line store reads (one read
// port), a lookup, multiply and accumulate lane pipe, an 8-step divide per lane and the push.
// Reset clears positions and the output valid, sets sizes to 1024 by 1024; memories are not cleared.
module range_weighted_window_filter_unit import rwwf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  rwwf_in_if.sink          in_i,
  rwwf_out_if.source       out_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_RUN, ST_WAIT, ST_PUSH} state_e;

  state_e           state_q;
  logic [DIM_W-1:0] wcfg_q, hcfg_q, ew, eh;
  logic [POS_W-1:0] ipos_q, opos_q, ip_e, op_e, ip_n, total, delay;
  logic [PTR_W-1:0] iptr_q, optr_q, iptr_e, optr_e, pbase_q, rowb_q, raddr;
  logic [PTR_W:0]   rsum, asum;
  logic [POS_W-1:0] p_q;
  logic [DIM_W:0]   rem_q, trial;
  logic [$clog2(POS_W+1)-1:0] cnt_q;
  logic [WIN_W-1:0] i_q, j_q;
  logic             first_q, last_q;
  logic             fire, sof, pix_ok, emit, mem_we;
  logic [23:0]      line_mem [RING];
  logic [23:0]      rd_q;
  lane_ctrl_t       ctrl_s0, ctrl_q;
  logic [7:0]       res [3];
  logic             done [3];
  logic             ov_q;
  logic [7:0]       ored_q, ogrn_q, oblu_q;
  logic             olast_q;

  assign ew = (wcfg_q == '0) ? DIM_W'(1) :
              (32'(wcfg_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : wcfg_q;
  assign eh = (hcfg_q == '0) ? DIM_W'(1) :
              (32'(hcfg_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : hcfg_q;
  assign total = POS_W'(ew) * POS_W'(eh);
  assign delay = POS_W'(ew) * POS_W'(WIN - 1) + POS_W'(WIN - 1);

  assign in_i.ready = (state_q == ST_IDLE);
  assign fire   = in_i.valid && in_i.ready;
  assign sof    = (in_i.kind == KIND_PIXEL) && in_i.start_of_frame;
  assign ip_e   = sof ? '0 : ipos_q;
  assign op_e   = sof ? '0 : opos_q;
  assign iptr_e = sof ? '0 : iptr_q;
  assign optr_e = sof ? '0 : optr_q;
  assign ip_n   = ip_e + POS_W'(1);
  assign pix_ok = (in_i.kind == KIND_PIXEL) && (ip_e < total);
  assign emit   = (pix_ok && (op_e < total) && ((ip_n - op_e) > delay)) ||
                  ((in_i.kind == KIND_FLUSH) && (ipos_q >= total) && (opos_q < total));
  assign mem_we = fire && pix_ok;

  assign trial = {rem_q[DIM_W-1:0], p_q[POS_W-1]};
  assign asum  = (PTR_W+1)'(rowb_q) + (PTR_W+1)'(j_q);
  assign rsum  = (PTR_W+1)'(rowb_q) + (PTR_W+1)'(ew);
  assign raddr = first_q ? pbase_q :
                 (asum >= (PTR_W+1)'(RING)) ? PTR_W'(asum - (PTR_W+1)'(RING)) : PTR_W'(asum);

  always_comb begin
    ctrl_s0 = '0;
    if (state_q == ST_RUN) begin
      ctrl_s0.centre = first_q;
      ctrl_s0.elem   = !first_q && ((POS_W+1)'(p_q) + (POS_W+1)'(i_q) < (POS_W+1)'(eh)) &&
                       ((DIM_W+1)'(rem_q) + (DIM_W+1)'(j_q) < (DIM_W+1)'(ew));
      ctrl_s0.last   = !first_q && (i_q == WIN_W'(WIN - 1)) && (j_q == WIN_W'(WIN - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[iptr_e] <= {in_i.pixel_red, in_i.pixel_green, in_i.pixel_blue};
    end
    rd_q <= line_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PUSH && (!ov_q || out_o.ready)) begin
      ored_q  <= res[0];
      ogrn_q  <= res[1];
      oblu_q  <= res[2];
      olast_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wcfg_q  <= DIM_W'(1024);
      hcfg_q  <= DIM_W'(1024);
      ipos_q  <= '0;
      opos_q  <= '0;
      iptr_q  <= '0;
      optr_q  <= '0;
      pbase_q <= '0;
      rowb_q  <= '0;
      p_q     <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
      ctrl_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      ctrl_q <= ctrl_s0;
      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WIDTH) begin
          wcfg_q <= cfg_data_i;
        end else begin
          hcfg_q <= cfg_data_i;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (fire && in_i.kind == KIND_PIXEL) begin
            ipos_q <= pix_ok ? ip_n : ip_e;
            iptr_q <= !pix_ok ? iptr_e :
                      (iptr_e == PTR_W'(RING - 1)) ? '0 : iptr_e + PTR_W'(1);
            opos_q <= op_e;
            optr_q <= optr_e;
          end
          if (fire && emit) begin
            p_q     <= op_e;
            pbase_q <= optr_e;
            last_q  <= (op_e + POS_W'(1)) == total;
            opos_q  <= op_e + POS_W'(1);
            optr_q  <= (optr_e == PTR_W'(RING - 1)) ? '0 : optr_e + PTR_W'(1);
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (trial >= (DIM_W+1)'(ew)) begin
            rem_q <= trial - (DIM_W+1)'(ew);
            p_q   <= {p_q[POS_W-2:0], 1'b1};
          end else begin
            rem_q <= trial;
            p_q   <= {p_q[POS_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q + ($clog2(POS_W+1))'(1);
          if (cnt_q == ($clog2(POS_W+1))'(POS_W - 1)) begin
            i_q     <= '0;
            j_q     <= '0;
            first_q <= 1'b1;
            rowb_q  <= pbase_q;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (first_q) begin
            first_q <= 1'b0;
          end else if (j_q == WIN_W'(WIN - 1)) begin
            j_q    <= '0;
            i_q    <= i_q + WIN_W'(1);
            rowb_q <= (rsum >= (PTR_W+1)'(RING)) ? PTR_W'(rsum - (PTR_W+1)'(RING))
                                                 : PTR_W'(rsum);
            if (i_q == WIN_W'(WIN - 1)) begin
              state_q <= ST_WAIT;
            end
          end else begin
            j_q <= j_q + WIN_W'(1);
          end
        end
        ST_WAIT: begin
          if (done[0] && done[1] && done[2]) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!ov_q || out_o.ready) begin
            ov_q    <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    rwwf_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tbl_we_i   (fire && in_i.kind == KIND_LOAD),
      .tbl_idx_i  (in_i.table_index),
      .tbl_data_i (in_i.table_weight),
      .ctrl_i     (ctrl_q),
      .pix_i      (rd_q[23-8*c -: 8]),
      .res_o      (res[c]),
      .done_o     (done[c])
    );
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_red       = ored_q;
  assign out_o.out_green     = ogrn_q;
  assign out_o.out_blue      = oblu_q;
  assign out_o.last_of_frame = olast_q;

endmodule
